[hw/rtl/ttrrs_pkg.sv]
// Shared constants, codes and types for the task table round-robin scheduler.
package ttrrs_pkg;

    localparam int SLOTS     = 16;
    localparam int SLOT_BITS = $clog2(SLOTS);
    localparam int CNT_BITS  = $clog2(SLOTS + 1);
    localparam int ID_BITS   = 32;

    localparam int OP_BITS     = 2;
    localparam int STATUS_BITS = 3;
    localparam int IDX_W       = 4;
    localparam int IDENT_W     = 32;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 40;

    localparam logic [1:0] ST_FREE  = 2'd0;
    localparam logic [1:0] ST_READY = 2'd1;
    localparam logic [1:0] ST_RUN   = 2'd2;

    localparam logic [OP_BITS-1:0] OP_CREATE = 2'd0;
    localparam logic [OP_BITS-1:0] OP_KILL   = 2'd1;
    localparam logic [OP_BITS-1:0] OP_SCHED  = 2'd2;
    localparam logic [OP_BITS-1:0] OP_YIELD  = 2'd3;

    localparam logic [STATUS_BITS-1:0] STS_OK       = 3'd0;
    localparam logic [STATUS_BITS-1:0] STS_NO_FREE  = 3'd1;
    localparam logic [STATUS_BITS-1:0] STS_NO_TASK  = 3'd2;
    localparam logic [STATUS_BITS-1:0] STS_KERNEL   = 3'd3;
    localparam logic [STATUS_BITS-1:0] STS_NO_READY = 3'd4;

    typedef struct packed {
        logic                 push;
        logic                 pop;
        logic [SLOT_BITS-1:0] push_slot;
    } t_stack_ctl;

    typedef struct packed {
        logic [CNT_BITS-1:0]  count;
        logic [SLOT_BITS-1:0] top_slot;
    } t_stack_sts;

    function automatic logic [SLOT_BITS-1:0] slot_inc(input logic [SLOT_BITS-1:0] idx);
        logic [SLOT_BITS-1:0] res;
        if (idx == SLOT_BITS'(SLOTS - 1)) begin
            res = '0;
        end else begin
            res = idx + SLOT_BITS'(1);
        end
        return res;
    endfunction

endpackage

[hw/rtl/ttrrs_free_stack.sv]
// Last-in-first-out stack of free slot numbers with fill count.
module ttrrs_free_stack
    import ttrrs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_stack_ctl i_ctl,
    output t_stack_sts o_sts
);

    logic [SLOT_BITS-1:0] r_entry [SLOTS];
    logic [CNT_BITS-1:0]  r_count;
    logic [CNT_BITS-1:0]  top_ptr;

    assign top_ptr        = r_count - CNT_BITS'(1);
    assign o_sts.count    = r_count;
    assign o_sts.top_slot = r_entry[top_ptr[SLOT_BITS-1:0]];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                r_entry[i] <= SLOT_BITS'(SLOTS - 1 - i);
            end
            r_count <= CNT_BITS'(SLOTS);
        end else if (i_ctl.pop && r_count != '0) begin
            r_count <= r_count - CNT_BITS'(1);
        end else if (i_ctl.push && r_count < CNT_BITS'(SLOTS)) begin
            r_entry[r_count[SLOT_BITS-1:0]] <= i_ctl.push_slot;
            r_count <= r_count + CNT_BITS'(1);
        end
    end

endmodule

[hw/rtl/task_table_round_robin_scheduler.sv]
// Top level: task slot table with create, kill, round-robin schedule and yield.
//
//  channel | dir | tdata (low bit up)                    | tuser
//  s_axis  | in  | target_id[31:0], user_task[32], pad   | op[1:0]
//  m_axis  | out | slot_index[3:0], task_ident[35:4], pad| status[2:0]
//
// Create and yield load the result register at accept and enter the done state,
// which loads the output word once the output is free. Kill and schedule step
// the shared read port over one slot per cycle, up to SLOTS slots. Reset is
// synchronous: all slots free, free stack full with slot 0 on top, no running
// task. s_axis_tready is high only while idle; a waiting result holds the block
// in the done state and so holds back the next accept.
module task_table_round_robin_scheduler
    import ttrrs_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,   // target_id, user_task
    input  logic [OP_BITS-1:0]     s_axis_tuser,   // op
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_DATA_W-1:0]  m_axis_tdata,   // slot_index, task_ident
    output logic [STATUS_BITS-1:0] m_axis_tuser    // status
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_KILL  = 2'd1;
    localparam logic [1:0] S_SCHED = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]             r_state;
    logic [1:0]             r_slot_state [SLOTS];
    logic [ID_BITS-1:0]     r_slot_ident [SLOTS];
    logic                   r_slot_user  [SLOTS];
    logic [ID_BITS-1:0]     r_last_ident;
    logic [SLOT_BITS-1:0]   r_next_start;
    logic                   r_run_valid;
    logic [SLOT_BITS-1:0]   r_run_slot;
    logic [SLOT_BITS-1:0]   r_idx;
    logic [SLOT_BITS-1:0]   r_cnt;
    logic [ID_BITS-1:0]     r_target;
    logic [STATUS_BITS-1:0] r_res_status;
    logic [SLOT_BITS-1:0]   r_res_slot;
    logic [ID_BITS-1:0]     r_res_ident;

    logic                   in_acc;
    logic [OP_BITS-1:0]     in_op;
    logic [ID_BITS-1:0]     in_target;
    logic                   in_user;
    logic [SLOT_BITS-1:0]   rd_addr;
    logic [1:0]             rd_state;
    logic [ID_BITS-1:0]     rd_ident;
    logic                   rd_user;
    logic                   rd_live;
    logic                   scan_last;
    logic                   kill_hit;
    logic                   kill_ok;
    logic                   create_ok;
    logic                   out_free;
    logic [SLOTS-1:0]       free_vec;
    t_stack_ctl             stk_ctl;
    t_stack_sts             stk_sts;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign in_op         = s_axis_tuser;
    assign in_target     = ID_BITS'(s_axis_tdata[31:0]);
    assign in_user       = s_axis_tdata[32];

    // one read port on the slot table, shared by the scan and the running slot
    assign rd_addr   = (r_state == S_IDLE) ? r_run_slot : r_idx;
    assign rd_state  = r_slot_state[rd_addr];
    assign rd_ident  = r_slot_ident[rd_addr];
    assign rd_user   = r_slot_user[rd_addr];
    assign rd_live   = (rd_state == ST_READY) || (rd_state == ST_RUN);
    assign scan_last = (r_cnt == SLOT_BITS'(SLOTS - 1));
    assign kill_hit  = (r_state == S_KILL) && rd_live && (rd_ident == r_target);
    assign kill_ok   = kill_hit && rd_user;
    assign create_ok = in_acc && (in_op == OP_CREATE) && (stk_sts.count != '0);
    assign out_free  = !m_axis_tvalid || m_axis_tready;

    assign stk_ctl.pop       = create_ok;
    assign stk_ctl.push      = kill_ok;
    assign stk_ctl.push_slot = r_idx;

    ttrrs_free_stack u_free_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (stk_ctl),
        .o_sts   (stk_sts)
    );

    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            free_vec[i] = (r_slot_state[i] == ST_FREE);
        end
    end

    always_ff @(posedge i_clk) begin
        if (create_ok) begin
            r_slot_ident[stk_sts.top_slot] <= r_last_ident + ID_BITS'(1);
            r_slot_user[stk_sts.top_slot]  <= in_user;
        end
        if (in_acc) begin
            r_target <= in_target;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            for (int i = 0; i < SLOTS; i++) begin
                r_slot_state[i] <= ST_FREE;
            end
            r_last_ident <= '0;
            r_next_start <= '0;
            r_run_valid  <= 1'b0;
            r_run_slot   <= '0;
            r_idx        <= '0;
            r_cnt        <= '0;
            r_res_status <= STS_OK;
            r_res_slot   <= '0;
            r_res_ident  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cnt <= '0;
                        unique case (in_op)
                            OP_CREATE: begin
                                r_state <= S_DONE;
                                if (create_ok) begin
                                    r_last_ident <= r_last_ident + ID_BITS'(1);
                                    r_slot_state[stk_sts.top_slot] <= ST_READY;
                                    r_res_status <= STS_OK;
                                    r_res_slot   <= stk_sts.top_slot;
                                    r_res_ident  <= r_last_ident + ID_BITS'(1);
                                end else begin
                                    r_res_status <= STS_NO_FREE;
                                    r_res_slot   <= '0;
                                    r_res_ident  <= '0;
                                end
                            end
                            OP_KILL: begin
                                r_idx   <= '0;
                                r_state <= S_KILL;
                            end
                            OP_SCHED: begin
                                // return the running task to ready before the scan
                                if (r_run_valid && rd_state == ST_RUN) begin
                                    r_slot_state[r_run_slot] <= ST_READY;
                                end
                                r_run_valid <= 1'b0;
                                r_idx       <= r_next_start;
                                r_state     <= S_SCHED;
                            end
                            default: begin
                                r_state <= S_DONE;
                                if (r_run_valid && rd_state == ST_RUN) begin
                                    r_slot_state[r_run_slot] <= ST_READY;
                                    r_res_status <= STS_OK;
                                    r_res_slot   <= r_run_slot;
                                    r_res_ident  <= rd_ident;
                                end else begin
                                    r_res_status <= STS_NO_TASK;
                                    r_res_slot   <= '0;
                                    r_res_ident  <= '0;
                                end
                                r_run_valid <= 1'b0;
                            end
                        endcase
                    end
                end
                S_KILL: begin
                    if (kill_hit) begin
                        r_state <= S_DONE;
                        if (rd_user) begin
                            r_slot_state[r_idx] <= ST_FREE;
                            if (r_run_valid && r_run_slot == r_idx) begin
                                r_run_valid <= 1'b0;
                            end
                            r_res_status <= STS_OK;
                            r_res_slot   <= r_idx;
                            r_res_ident  <= rd_ident;
                        end else begin
                            r_res_status <= STS_KERNEL;
                            r_res_slot   <= '0;
                            r_res_ident  <= '0;
                        end
                    end else if (scan_last) begin
                        r_state      <= S_DONE;
                        r_res_status <= STS_NO_TASK;
                        r_res_slot   <= '0;
                        r_res_ident  <= '0;
                    end else begin
                        r_idx <= slot_inc(r_idx);
                        r_cnt <= r_cnt + SLOT_BITS'(1);
                    end
                end
                S_SCHED: begin
                    if (rd_state == ST_READY) begin
                        r_state             <= S_DONE;
                        r_slot_state[r_idx] <= ST_RUN;
                        r_run_valid         <= 1'b1;
                        r_run_slot          <= r_idx;
                        r_next_start        <= slot_inc(r_idx);
                        r_res_status        <= STS_OK;
                        r_res_slot          <= r_idx;
                        r_res_ident         <= rd_ident;
                    end else if (scan_last) begin
                        r_state      <= S_DONE;
                        r_res_status <= STS_NO_READY;
                        r_res_slot   <= '0;
                        r_res_ident  <= '0;
                    end else begin
                        r_idx <= slot_inc(r_idx);
                        r_cnt <= r_cnt + SLOT_BITS'(1);
                    end
                end
                default: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
            endcase
        end
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (r_state == S_DONE && out_free) begin
            m_axis_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && out_free) begin
            m_axis_tuser <= r_res_status;
            m_axis_tdata <= {4'd0, IDENT_W'(r_res_ident), IDX_W'(r_res_slot)};
        end
    end

    a_run_slot_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && r_run_valid) |-> (r_slot_state[r_run_slot] == ST_RUN))
        else $error("running slot not in running state");

    a_free_count_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (32'(stk_sts.count) == 32'($countones(free_vec))))
        else $error("free stack count disagrees with free slots");

    a_free_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        stk_sts.count <= CNT_BITS'(SLOTS))
        else $error("free stack count overflow");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser <= STS_NO_READY))
        else $error("illegal status code");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tuser != STS_OK) |-> (m_axis_tdata == '0))
        else $error("error word carries nonzero slot or id");

endmodule
